/* hw/rtl/uart_line_command_recognizer_macros.svh */
// ----------------------------------------------------------------------------
// uart line command recognizer assertion macros
// shared concurrent check forms, clocked on clk_i and quiet during reset
// ----------------------------------------------------------------------------
`ifndef UART_LINE_COMMAND_RECOGNIZER_MACROS_SVH
`define UART_LINE_COMMAND_RECOGNIZER_MACROS_SVH

// same-cycle implication
`define ULCR_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("ulcr check failed");

// next-cycle implication
`define ULCR_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("ulcr check failed");

`endif

/* hw/rtl/ulcr_pkg.sv */
// ----------------------------------------------------------------------------
// ulcr_pkg
// types, constants and keyword table of the line command recognizer
// ----------------------------------------------------------------------------
package ulcr_pkg;

  localparam int unsigned QUEUE_SLOTS = 8;
  localparam int unsigned LINE_LENGTH = 64;

  localparam int unsigned RING_IDX_W = $clog2(QUEUE_SLOTS);
  localparam int unsigned POS_W      = $clog2(LINE_LENGTH);
  localparam logic [POS_W-1:0] POS_LIMIT = POS_W'(LINE_LENGTH - 1);

  localparam int unsigned CODE_W   = 3;
  localparam int unsigned KW_COUNT = 6;
  localparam int unsigned KW_MAX   = 16;
  localparam int unsigned KW_BITS  = KW_MAX * 8;
  localparam int unsigned KW_IDX_W = 4;

  localparam logic [7:0] CHAR_CR = 8'h0D;
  localparam logic [7:0] CHAR_LF = 8'h0A;

  localparam logic [KW_COUNT-1:0] ALL_ALIVE = '1;

  // right-justified ascii, first character in the high byte
  localparam logic [KW_BITS-1:0] KW_STR [KW_COUNT] = '{
    KW_BITS'(80'h6c65645f616c6c5f6f6e),
    KW_BITS'(88'h6c65645f616c6c5f6f6666),
    KW_BITS'(104'h6c65645f6b6570706f6e5f7570),
    KW_BITS'(120'h6c65645f6b6565706f6e5f646f776e),
    KW_BITS'(72'h666c6f7765725f6f6e),
    KW_BITS'(80'h666c6f7765725f6f6666)
  };

  localparam logic [KW_IDX_W-1:0] KW_LEN [KW_COUNT] = '{
    4'd10, 4'd11, 4'd13, 4'd15, 4'd9, 4'd10
  };

  typedef enum logic [1:0] {
    OP_NONE,
    OP_PUSH,
    OP_POP
  } op_kind_e;

  typedef struct packed {
    op_kind_e          kind;
    logic [CODE_W-1:0] code;
  } op_t;

  // character idx of keyword k
  function automatic logic [7:0] kw_char(input int unsigned k,
                                         input logic [KW_IDX_W-1:0] idx);
    logic [KW_BITS-1:0] lj;
    lj = KW_STR[k] << ((KW_MAX - int'(KW_LEN[k])) * 8);
    return lj[KW_BITS - 1 - 8 * int'(idx) -: 8];
  endfunction

endpackage

/* hw/rtl/ulcr_front.sv */
// ----------------------------------------------------------------------------
// ulcr_front
// accepts requests, tracks keyword matching per byte, emits ring operations
// ----------------------------------------------------------------------------
module ulcr_front import ulcr_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic       cmd_i,
  input  logic [7:0] rx_byte_i,
  input  logic       opq_full_i,
  output logic       op_valid_o,
  output op_t        op_o
);

  logic [KW_COUNT-1:0] alive_q, alive_d, alive_trk;
  logic [POS_W-1:0]    pos_q, pos_d;
  logic [CODE_W-1:0]   fin_code;
  logic                in_take;
  logic                is_eol;

  assign in_stall_o = opq_full_i;
  assign in_take    = in_valid_i && !opq_full_i;
  assign op_valid_o = in_take;
  assign is_eol     = (rx_byte_i == CHAR_CR) || (rx_byte_i == CHAR_LF);

  always_comb begin
    alive_trk = alive_q;
    for (int unsigned k = 0; k < KW_COUNT; k++) begin
      if (pos_q < POS_W'(KW_LEN[k]) &&
          kw_char(k, pos_q[KW_IDX_W-1:0]) != rx_byte_i) begin
        alive_trk[k] = 1'b0;
      end
    end
  end

  // first matching keyword wins, so scan from the back
  always_comb begin
    fin_code = '0;
    for (int k = KW_COUNT - 1; k >= 0; k--) begin
      if (alive_q[k] && pos_q >= POS_W'(KW_LEN[k])) begin
        fin_code = CODE_W'(k + 1);
      end
    end
  end

  always_comb begin
    alive_d      = alive_q;
    pos_d        = pos_q;
    op_o.kind    = OP_NONE;
    op_o.code    = '0;
    if (cmd_i) begin
      op_o.kind = OP_POP;
    end else if (is_eol) begin
      op_o.kind = OP_PUSH;
      op_o.code = fin_code;
      if (in_take) begin
        alive_d = ALL_ALIVE;
        pos_d   = '0;
      end
    end else if (in_take && pos_q < POS_LIMIT) begin
      alive_d = alive_trk;
      pos_d   = pos_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alive_q <= ALL_ALIVE;
      pos_q   <= '0;
    end else begin
      alive_q <= alive_d;
      pos_q   <= pos_d;
    end
  end

endmodule

/* hw/rtl/ulcr_opq.sv */
// ----------------------------------------------------------------------------
// ulcr_opq
// two-entry queue of ring operations between front and back
// ----------------------------------------------------------------------------
module ulcr_opq import ulcr_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic wr_valid_i,
  input  op_t  wr_op_i,
  output logic full_o,
  output logic rd_valid_o,
  input  logic rd_take_i,
  output op_t  rd_op_o
);

  op_t        slot_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       do_wr, do_rd;

  assign full_o     = cnt_q == 2'd2;
  assign rd_valid_o = cnt_q != 2'd0;
  assign rd_op_o    = slot_q[rd_ptr_q];
  assign do_wr      = wr_valid_i && !full_o;
  assign do_rd      = rd_take_i && rd_valid_o;

  always_comb begin
    wr_ptr_d = do_wr ? !wr_ptr_q : wr_ptr_q;
    rd_ptr_d = do_rd ? !rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_wr && !do_rd) begin
      cnt_d = cnt_q + 2'd1;
    end else if (do_rd && !do_wr) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      slot_q[wr_ptr_q] <= wr_op_i;
    end
  end

endmodule

/* hw/rtl/ulcr_back.sv */
// ----------------------------------------------------------------------------
// ulcr_back
// code ring with head and tail, result register toward the output channel
// ----------------------------------------------------------------------------
module ulcr_back import ulcr_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              op_valid_i,
  input  op_t               op_i,
  output logic              op_take_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic              queue_empty_o,
  output logic [CODE_W-1:0] command_code_o,
  output logic              line_dropped_o,
  output logic              line_done_o
);

  `include "uart_line_command_recognizer_macros.svh"

  logic [CODE_W-1:0]     ring_q [QUEUE_SLOTS];
  logic [RING_IDX_W-1:0] head_q, head_d, tail_q, tail_d, tail_nxt;
  logic                  out_valid_q, out_valid_d;
  logic                  empty_q, empty_d;
  logic [CODE_W-1:0]     code_q, code_d;
  logic                  dropped_q, dropped_d;
  logic                  done_q, done_d;
  logic                  back_ready;
  logic                  ring_empty, ring_full;
  logic                  ring_wr;
  logic                  pop_take;
  logic                  ring_rd;

  assign back_ready = !out_valid_q || !out_stall_i;
  assign op_take_o  = op_valid_i && back_ready;

  assign tail_nxt   = (tail_q == RING_IDX_W'(QUEUE_SLOTS - 1)) ? '0 : tail_q + 1'b1;
  assign ring_empty = head_q == tail_q;
  assign ring_full  = tail_nxt == head_q;
  assign ring_wr    = op_take_o && op_i.kind == OP_PUSH && !ring_full;
  assign pop_take   = op_take_o && op_i.kind == OP_POP;
  assign ring_rd    = pop_take && !ring_empty;

  always_comb begin
    head_d      = head_q;
    tail_d      = tail_q;
    out_valid_d = out_valid_q && out_stall_i;
    empty_d     = empty_q;
    code_d      = code_q;
    dropped_d   = dropped_q;
    done_d      = done_q;
    if (op_take_o) begin
      out_valid_d = 1'b1;
      empty_d     = 1'b0;
      code_d      = '0;
      dropped_d   = 1'b0;
      done_d      = 1'b0;
      case (op_i.kind)
        OP_POP: begin
          if (ring_empty) begin
            empty_d = 1'b1;
          end else begin
            head_d = (head_q == RING_IDX_W'(QUEUE_SLOTS - 1)) ? '0 : head_q + 1'b1;
          end
        end
        OP_PUSH: begin
          if (ring_full) begin
            dropped_d = 1'b1;
          end else begin
            done_d = 1'b1;
            tail_d = tail_nxt;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q      <= '0;
      tail_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      head_q      <= head_d;
      tail_q      <= tail_d;
      out_valid_q <= out_valid_d;
    end
  end

  // popped code is read straight from the ring into the result register
  always_ff @(posedge clk_i) begin
    empty_q   <= empty_d;
    dropped_q <= dropped_d;
    done_q    <= done_d;
    if (ring_rd) begin
      code_q <= ring_q[head_q];
    end else begin
      code_q <= code_d;
    end
    if (ring_wr) begin
      ring_q[tail_q] <= op_i.code;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign queue_empty_o  = empty_q;
  assign command_code_o = code_q;
  assign line_dropped_o = dropped_q;
  assign line_done_o    = done_q;

  `ULCR_ASSERT_NOW(a_one_flag, out_valid_q, $countones({empty_q, dropped_q, done_q}) <= 1)
  `ULCR_ASSERT_NOW(a_code_not_empty, out_valid_q && code_q != '0, !empty_q)
  `ULCR_ASSERT_NEXT(a_pop_empty, pop_take && ring_empty, out_valid_q && empty_q && code_q == '0)
  `ULCR_ASSERT_NEXT(a_push_not_wrap, ring_wr, head_q != tail_q)

endmodule

/* hw/rtl/uart_line_command_recognizer.sv */
// ----------------------------------------------------------------------------
// uart_line_command_recognizer
// line command recognizer: bytes build lines, each line end queues a keyword
// code in a ring, a poll request pops the oldest code
// ----------------------------------------------------------------------------
//   channel | handshake                | payload
//   --------+--------------------------+---------------------------------------
//   in      | in_valid_i / in_stall_o  | cmd_i, rx_byte_i
//   out     | out_valid_o / out_stall_i| queue_empty_o, command_code_o,
//           |                          | line_dropped_o, line_done_o
//
// one request per cycle sustained while the output is not stalled; a response
// passes the op queue write, then the result register, after its request is taken
// tracking: one compare per keyword per byte; the ring one slot a cycle unless stalled
// reset clears line state, ring pointers and both queues; ring contents are not cleared
// a stalled output fills the op queue, after which in_stall_o rises
module uart_line_command_recognizer import ulcr_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic              cmd_i,
  input  logic [7:0]        rx_byte_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic              queue_empty_o,
  output logic [CODE_W-1:0] command_code_o,
  output logic              line_dropped_o,
  output logic              line_done_o
);

  logic opq_full;
  logic wr_valid;
  op_t  wr_op;
  logic rd_valid;
  logic rd_take;
  op_t  rd_op;

  ulcr_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .cmd_i      (cmd_i),
    .rx_byte_i  (rx_byte_i),
    .opq_full_i (opq_full),
    .op_valid_o (wr_valid),
    .op_o       (wr_op)
  );

  ulcr_opq u_opq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (wr_valid),
    .wr_op_i    (wr_op),
    .full_o     (opq_full),
    .rd_valid_o (rd_valid),
    .rd_take_i  (rd_take),
    .rd_op_o    (rd_op)
  );

  ulcr_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .op_valid_i     (rd_valid),
    .op_i           (rd_op),
    .op_take_o      (rd_take),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .queue_empty_o  (queue_empty_o),
    .command_code_o (command_code_o),
    .line_dropped_o (line_dropped_o),
    .line_done_o    (line_done_o)
  );

endmodule
